// ===== design/gpsm_pkg.sv =====
// Shared constants, widths, state encoding and unit interface types for the gyro steering mixer.
package gpsm_pkg;

	// Field widths.
	localparam int SAMPLE_BITS = 10;
	localparam int FRAC_BITS   = 4;
	localparam int IN_W        = 16;
	localparam int DUTY_W      = 8;

	// Controller constants.
	localparam int GYRO_RANGE   = 2000;
	localparam int RANGE_W      = 11;
	localparam int WINDUP_LIMIT = 7500;
	localparam int WINDUP_W     = 13;
	localparam int CMD_LIMIT    = 100;
	localparam int CMD_LIM_W    = 7;
	localparam int DUTY_FULL    = 255;
	localparam int P_GAIN       = 19661;
	localparam int I_GAIN       = 1311;
	localparam int GAIN_W       = 15;
	localparam int GAIN_SHIFT   = 16;
	localparam int ZERO_RESET   = 512;

	// Scaled constants in the fixed-point format.
	localparam int RATE_SCALE = GYRO_RANGE << FRAC_BITS;
	localparam int WINDUP_Q   = WINDUP_LIMIT << FRAC_BITS;
	localparam int CMD_LIM_Q  = CMD_LIMIT << FRAC_BITS;

	// Duty scaling by the command limit, 25 * 2^(FRAC_BITS + 2): the power-of-two part is a
	// shift and the division by 25 is a multiplication by ceil(2^17 / 25), exact for the
	// shifted numerator range of at most 255 * 25.
	localparam int DUTY_PRE_SHIFT = FRAC_BITS + 2;
	localparam int DUTY_RECIP     = 5243;
	localparam int DUTY_SHIFT     = 17;

	// Divider sizing: the divider serves the rate scaling only.
	localparam int RATE_NUM_W = SAMPLE_BITS + RANGE_W + FRAC_BITS;
	localparam int DUTY_NUM_W = CMD_LIM_W + FRAC_BITS + DUTY_W;
	localparam int DIV_W      = RATE_NUM_W;
	localparam int DEN_W      = SAMPLE_BITS;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_CYC    = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DIV_PW     = DIV_CYC * DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYC + 1);

	// Datapath widths.
	localparam int RATE_W  = DIV_W + 1;
	localparam int TGT_W   = IN_W + FRAC_BITS;
	localparam int ERR_W   = ((TGT_W > RATE_W) ? TGT_W : RATE_W) + 1;
	localparam int ES_W    = WINDUP_W + FRAC_BITS + 1;
	localparam int SUM_W   = ((ERR_W > ES_W) ? ERR_W : ES_W) + 1;
	localparam int MUL_A_W = (SAMPLE_BITS > SUM_W) ? SAMPLE_BITS : SUM_W;
	localparam int MUL_B_W = (RANGE_W + FRAC_BITS > GAIN_W) ? RANGE_W + FRAC_BITS : GAIN_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int TERM_W  = SUM_W;
	localparam int MIX_W   = TERM_W + 1;
	localparam int PWR_W   = IN_W + FRAC_BITS;
	localparam int CMD_W   = ((MIX_W > PWR_W) ? MIX_W : PWR_W) + 1;
	localparam int LIM_W   = CMD_LIM_W + FRAC_BITS;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_RSTART,
		ST_RATE,
		ST_PGAIN,
		ST_IGAIN,
		ST_MIX,
		ST_CMD,
		ST_LSTART,
		ST_LDUTY,
		ST_RDUTY,
		ST_PUT
	} seq_state_t;

	// Divider request and response.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

	// Multiplier operands.
	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

// ===== design/gpsm_div.sv =====
// Shared iterative unsigned divider, two restoring quotient bits per cycle.
module gpsm_div
	import gpsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DIV_PW-1:0]    quo_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_n;
	logic [DIV_PW-1:0]    quo_n;
	logic [DEN_W:0]       trial;

	// Two restoring steps: shift in the next numerator bit, subtract when it fits.
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		trial = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem_n, quo_n[DIV_PW-1]};
			quo_n = {quo_n[DIV_PW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_n    = DEN_W'(trial - {1'b0, den_q});
				quo_n[0] = 1'b1;
			end else begin
				rem_n = trial[DEN_W-1:0];
			end
		end
	end

	// Iteration control; done pulses for one cycle after the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == DIV_CNT_W'(DIV_CYC - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q + 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and numerator/quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= DIV_PW'(req.num);
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q[DIV_W-1:0];

endmodule

// ===== design/gpsm_mul.sv =====
// Shared unsigned multiplier with a registered product.
module gpsm_mul
	import gpsm_pkg::*;
(
	input  logic              clk,
	input  mul_req_t          req,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	// One product per cycle, taken from the product register by the sequencer in the following state.
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
	end

	assign prod = prod_q;

endmodule

// ===== design/gyro_pi_steering_motor_mixer_unit.sv =====
// Top level: sequencer and datapath of the gyro PI steering controller and motor mixer.
//
// Each accepted word carries a raw gyro sample, a drive power and a yaw-rate target, and
// yields one word of four motor duty bytes. The block works on one word at a time and holds
// in_stall high from acceptance until its result is loaded into the output register; the
// next word can be accepted on the cycle after that. The time per word is set by the
// shared divider, which runs one pass per word for the rate scaling at two quotient bits
// per cycle, and by the shared multiplier, which serves the rate scaling, both gains and
// the two duty scalings one after the other. A finished word waits in the output register
// while a new word is accepted. The user is to write gyro_zero through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block itself does not enforce this. A value
// of zero is treated as one.
module gyro_pi_steering_motor_mixer_unit
	import gpsm_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic        [SAMPLE_BITS-1:0] cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic        [SAMPLE_BITS-1:0] gyro_sample,
	input  logic signed [IN_W-1:0]        drive_power,
	input  logic signed [IN_W-1:0]        yaw_target,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic        [DUTY_W-1:0]      left_forward,
	output logic        [DUTY_W-1:0]      left_backward,
	output logic        [DUTY_W-1:0]      right_forward,
	output logic        [DUTY_W-1:0]      right_backward
);

	seq_state_t state_q;
	seq_state_t state_d;

	logic [SAMPLE_BITS-1:0] zero_q;
	logic signed [ES_W-1:0] es_q;
	logic                   out_valid_q;

	logic [SAMPLE_BITS-1:0]   diff_mag_q;
	logic                     diff_neg_q;
	logic signed [IN_W-1:0]   power_q;
	logic signed [IN_W-1:0]   target_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [TERM_W-1:0] p_term_q;
	logic signed [MIX_W-1:0]  mix_q;
	logic [LIM_W-1:0]         lmag_q;
	logic                     lpos_q;
	logic [LIM_W-1:0]         rmag_q;
	logic                     rpos_q;
	logic [DUTY_W-1:0]        lduty_q;
	logic [DUTY_W-1:0]        rduty_q;
	logic [DUTY_W-1:0]        lf_q;
	logic [DUTY_W-1:0]        lb_q;
	logic [DUTY_W-1:0]        rf_q;
	logic [DUTY_W-1:0]        rb_q;

	logic in_accept;
	logic out_free;

	logic [SAMPLE_BITS-1:0]   zero_eff;
	logic signed [SAMPLE_BITS:0] diff;
	logic [SAMPLE_BITS:0]     diff_abs;
	logic signed [RATE_W-1:0] rate;
	logic signed [TGT_W-1:0]  tgt_fx;
	logic signed [ERR_W-1:0]  err_d;
	logic [ERR_W-1:0]         err_abs;
	logic [ES_W-1:0]          es_abs;
	logic signed [SUM_W-1:0]  sum;
	logic                     windup;
	logic signed [TERM_W-1:0] term_mag;
	logic signed [TERM_W-1:0] p_term_d;
	logic signed [TERM_W-1:0] i_term;
	logic signed [CMD_W-1:0]  pw_fx;
	logic signed [CMD_W-1:0]  left_cmd;
	logic signed [CMD_W-1:0]  right_cmd;
	logic [LIM_W:0]           left_lim;
	logic [LIM_W:0]           right_lim;
	logic [DUTY_NUM_W-1:0]    lnum;
	logic [DUTY_NUM_W-1:0]    rnum;

	div_req_t          div_req;
	div_rsp_t          div_rsp;
	mul_req_t          mul_req;
	logic [PROD_W-1:0] prod;

	// Clamp a command to the limit; returns the positive flag over the magnitude.
	function automatic logic [LIM_W:0] cmd_clamp(input logic signed [CMD_W-1:0] cmd);
		logic signed [CMD_W-1:0] lim;
		logic [CMD_W-1:0]        mag;
		lim = CMD_W'(CMD_LIM_Q);
		mag = cmd[CMD_W-1] ? CMD_W'(-cmd) : CMD_W'(cmd);
		if (cmd > lim) begin
			return {1'b1, LIM_W'(CMD_LIM_Q)};
		end else if (cmd < -lim) begin
			return {1'b0, LIM_W'(CMD_LIM_Q)};
		end else begin
			return {(!cmd[CMD_W-1]) && (cmd != '0), mag[LIM_W-1:0]};
		end
	endfunction

	gpsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	gpsm_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	// Handshake.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Sample offset from the zero reading.
	always_comb begin
		zero_eff = (zero_q == '0) ? SAMPLE_BITS'(1) : zero_q;
		diff     = $signed({1'b0, gyro_sample}) - $signed({1'b0, zero_eff});
		diff_abs = diff[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-diff) : (SAMPLE_BITS + 1)'(diff);
	end

	// Rate error, integral update with reset on windup, and gain terms.
	always_comb begin
		rate     = diff_neg_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
		tgt_fx   = TGT_W'(target_q) <<< FRAC_BITS;
		err_d    = ERR_W'(tgt_fx) - ERR_W'(rate);
		err_abs  = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
		es_abs   = es_q[ES_W-1] ? ES_W'(-es_q) : ES_W'(es_q);
		sum      = SUM_W'(es_q) + SUM_W'(err_q);
		windup   = (sum > SUM_W'(WINDUP_Q)) || (sum < -SUM_W'(WINDUP_Q));
		term_mag = $signed(TERM_W'(prod >> GAIN_SHIFT));
		p_term_d = err_q[ERR_W-1] ? -term_mag : term_mag;
		i_term   = es_q[ES_W-1] ? -term_mag : term_mag;
	end

	// Motor commands and the duty numerators.
	always_comb begin
		pw_fx     = CMD_W'(power_q) <<< FRAC_BITS;
		left_cmd  = pw_fx - CMD_W'(mix_q);
		right_cmd = pw_fx + CMD_W'(mix_q);
		left_lim  = cmd_clamp(left_cmd);
		right_lim = cmd_clamp(right_cmd);
		lnum      = DUTY_NUM_W'({lmag_q, DUTY_W'(0)}) - DUTY_NUM_W'(lmag_q);
		rnum      = DUTY_NUM_W'({rmag_q, DUTY_W'(0)}) - DUTY_NUM_W'(rmag_q);
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and requests to the shared units.
	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				mul_req.a = MUL_A_W'(diff_mag_q);
				mul_req.b = MUL_B_W'(RATE_SCALE);
				state_d   = ST_RSTART;
			end
			ST_RSTART: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_W'(prod);
				div_req.den   = DEN_W'(zero_eff);
				state_d       = ST_RATE;
			end
			ST_RATE: begin
				if (div_rsp.done) begin
					state_d = ST_PGAIN;
				end
			end
			ST_PGAIN: begin
				mul_req.a = MUL_A_W'(err_abs);
				mul_req.b = MUL_B_W'(P_GAIN);
				state_d   = ST_IGAIN;
			end
			ST_IGAIN: begin
				mul_req.a = MUL_A_W'(es_abs);
				mul_req.b = MUL_B_W'(I_GAIN);
				state_d   = ST_MIX;
			end
			ST_MIX: begin
				state_d = ST_CMD;
			end
			ST_CMD: begin
				state_d = ST_LSTART;
			end
			ST_LSTART: begin
				mul_req.a = MUL_A_W'(lnum >> DUTY_PRE_SHIFT);
				mul_req.b = MUL_B_W'(DUTY_RECIP);
				state_d   = ST_LDUTY;
			end
			ST_LDUTY: begin
				mul_req.a = MUL_A_W'(rnum >> DUTY_PRE_SHIFT);
				mul_req.b = MUL_B_W'(DUTY_RECIP);
				state_d   = ST_RDUTY;
			end
			ST_RDUTY: begin
				state_d = ST_PUT;
			end
			ST_PUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Zero register, kept integral and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q      <= SAMPLE_BITS'(ZERO_RESET);
			es_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				zero_q <= cfg_wr_data;
			end
			if (state_q == ST_PGAIN) begin
				es_q <= windup ? '0 : ES_W'(sum);
			end
			if ((state_q == ST_PUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, loaded in the state that produces each value.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			diff_mag_q <= diff_abs[SAMPLE_BITS-1:0];
			diff_neg_q <= diff[SAMPLE_BITS];
			power_q    <= drive_power;
			target_q   <= yaw_target;
		end
		if ((state_q == ST_RATE) && div_rsp.done) begin
			err_q <= err_d;
		end
		if (state_q == ST_IGAIN) begin
			p_term_q <= p_term_d;
		end
		if (state_q == ST_MIX) begin
			mix_q <= MIX_W'(p_term_q) + MIX_W'(i_term);
		end
		if (state_q == ST_CMD) begin
			lpos_q <= left_lim[LIM_W];
			lmag_q <= left_lim[LIM_W-1:0];
			rpos_q <= right_lim[LIM_W];
			rmag_q <= right_lim[LIM_W-1:0];
		end
		if (state_q == ST_LDUTY) begin
			lduty_q <= DUTY_W'(prod >> DUTY_SHIFT);
		end
		if (state_q == ST_RDUTY) begin
			rduty_q <= DUTY_W'(prod >> DUTY_SHIFT);
		end
		if ((state_q == ST_PUT) && out_free) begin
			lf_q <= lpos_q ? lduty_q : '0;
			lb_q <= lpos_q ? '0 : lduty_q;
			rf_q <= rpos_q ? rduty_q : '0;
			rb_q <= rpos_q ? '0 : rduty_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign left_forward   = lf_q;
	assign left_backward  = lb_q;
	assign right_forward  = rf_q;
	assign right_backward = rb_q;

endmodule
